FILE: hw/rtl/bmf_pkg.sv
// ----------------------------------------------------------------------------
// bmf_pkg
// Shared constants, types and register codes of the box mean filter.
// ----------------------------------------------------------------------------
package bmf_pkg;

    // Window geometry
    localparam int RADIUS     = 2;
    localparam int WIN        = 2 * RADIUS + 1;
    localparam int AREA       = WIN * WIN;
    localparam int LINES      = 2 * RADIUS;

    // Frame limits
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    // Field widths
    localparam int PIX_W      = 8;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;
    localparam int COL_W      = 10;
    localparam int ROW_W      = 12;

    // Line buffer: one word per column holds the previous rows of that column
    localparam int LINE_W     = PIX_W * LINES;
    localparam int LADDR_W    = $clog2(MAX_WIDTH);

    // Sum widths
    localparam int PIX_MAX    = (1 << PIX_W) - 1;
    localparam int CSUM_W     = $clog2(WIN * PIX_MAX + 1);
    localparam int SUM_W      = $clog2(AREA * PIX_MAX + 1);

    // Floor division by AREA as a multiply by a rounded-up reciprocal
    localparam int RECIP_SHIFT = SUM_W + $clog2(AREA);
    localparam int RECIP       = ((1 << RECIP_SHIFT) + AREA - 1) / AREA;
    localparam int PROD_W      = RECIP_SHIFT + PIX_W;

    // Register port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = REG_IDX_W'(1);

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(1024);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);

    // Effective frame size and restart strobe from the register block
    typedef struct packed {
        logic [WIDTH_W-1:0]  width;
        logic [HEIGHT_W-1:0] height;
        logic                restart;
    } frame_cfg_t;

    // Position of the incoming pixel and what it produces
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             emit;
        logic             last;
    } scan_pos_t;

    // Side information that travels with a result
    typedef struct packed {
        logic [ROW_W-1:0] center_row;
        logic [COL_W-1:0] center_col;
        logic             last;
    } result_tag_t;

endpackage

FILE: hw/rtl/box_mean_filter.sv
// ----------------------------------------------------------------------------
// box_mean_filter
// 2-D box filter: truncated mean over a square window on a raster pixel stream.
// ----------------------------------------------------------------------------
// Takes one 8-bit grey pixel per clock in raster order and returns one result
// per clock for every pixel that completes a window lying wholly inside the
// frame, while the result side does not stall; border centers give no result.
// A taken pixel request passes the line buffer read, the column sum, the
// window sum and then the divide into the output register, and the pipeline
// sustains one pixel per cycle while results are not stalled, limited by the
// single write and read port of the line buffer. The line buffer is not cleared
// after reset: every window only reads rows written earlier in the same frame.
// Writing either frame size register restarts the frame at the top left pixel;
// write registers only while no request is in flight.
// ----------------------------------------------------------------------------
module box_mean_filter (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bmf_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [bmf_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [bmf_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    input  logic [bmf_pkg::PIX_W-1:0]         pixel,
    input  logic                              pixel_valid,
    output logic                              pixel_stall,
    output logic [bmf_pkg::PIX_W-1:0]         mean_value,
    output logic [bmf_pkg::ROW_W-1:0]         center_row,
    output logic [bmf_pkg::COL_W-1:0]         center_col,
    output logic                              frame_last,
    output logic                              result_valid,
    input  logic                              result_stall
);

    import bmf_pkg::*;

    frame_cfg_t          cfg;
    scan_pos_t           pos;
    logic                accept;
    logic                line_wr_en;
    logic [LADDR_W-1:0]  line_wr_addr;
    logic [LINE_W-1:0]   line_wr_data;
    logic [LINE_W-1:0]   line_rd;

    assign accept = pixel_valid && !pixel_stall;

    // Frame size registers
    bmf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Raster position
    bmf_scan u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .accept (accept),
        .pos    (pos)
    );

    // Line buffer: read the column on request, write it back one stage later
    bmf_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .clk     (clk),
        .wr_en   (line_wr_en),
        .wr_addr (line_wr_addr),
        .wr_data (line_wr_data),
        .rd_en   (accept),
        .rd_addr (LADDR_W'(pos.col)),
        .rd_data (line_rd)
    );

    // Window datapath
    bmf_pipe u_pipe (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .pos          (pos),
        .pixel        (pixel),
        .line_rd      (line_rd),
        .pixel_stall  (pixel_stall),
        .line_wr_en   (line_wr_en),
        .line_wr_addr (line_wr_addr),
        .line_wr_data (line_wr_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .mean_value   (mean_value),
        .center_row   (center_row),
        .center_col   (center_col),
        .frame_last   (frame_last)
    );

endmodule

FILE: hw/rtl/bmf_ram.sv
// ----------------------------------------------------------------------------
// bmf_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and read; read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/bmf_cfg.sv
// ----------------------------------------------------------------------------
// bmf_cfg
// Frame size registers behind the APB port, clamped to the supported range.
// ----------------------------------------------------------------------------
module bmf_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bmf_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [bmf_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [bmf_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    output bmf_pkg::frame_cfg_t                 cfg
);

    import bmf_pkg::*;

    logic [WIDTH_W-1:0]   width_reg;
    logic [WIDTH_W-1:0]   width_next;
    logic [HEIGHT_W-1:0]  height_reg;
    logic [HEIGHT_W-1:0]  height_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr;
    logic                 restart;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr      = psel && penable && pwrite;

    // Decode the write request
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        restart     = 1'b0;
        if (wr)
        begin
            case (reg_idx)
                REG_IMAGE_WIDTH:
                begin
                    width_next = pwdata[WIDTH_W-1:0];
                    restart    = 1'b1;
                end
                REG_IMAGE_HEIGHT:
                begin
                    height_next = pwdata[HEIGHT_W-1:0];
                    restart     = 1'b1;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // Read back the stored values
    always_comb
    begin
        case (reg_idx)
            REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(width_reg);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(height_reg);
            default:          prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // Clamp: zero counts as one, oversize counts as the maximum
    always_comb
    begin
        if (width_reg == '0)
        begin
            cfg.width = WIDTH_W'(1);
        end
        else if (width_reg > WIDTH_W'(MAX_WIDTH))
        begin
            cfg.width = WIDTH_W'(MAX_WIDTH);
        end
        else
        begin
            cfg.width = width_reg;
        end

        if (height_reg == '0)
        begin
            cfg.height = HEIGHT_W'(1);
        end
        else if (height_reg > HEIGHT_W'(MAX_HEIGHT))
        begin
            cfg.height = HEIGHT_W'(MAX_HEIGHT);
        end
        else
        begin
            cfg.height = height_reg;
        end

        cfg.restart = restart;
    end

endmodule

FILE: hw/rtl/bmf_scan.sv
// ----------------------------------------------------------------------------
// bmf_scan
// Raster position counters: row and column of the next pixel of the frame.
// ----------------------------------------------------------------------------
module bmf_scan (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bmf_pkg::frame_cfg_t  cfg,
    input  logic                 accept,
    output bmf_pkg::scan_pos_t   pos
);

    import bmf_pkg::*;

    logic [COL_W-1:0]    col_reg;
    logic [COL_W-1:0]    col_next;
    logic [ROW_W-1:0]    row_reg;
    logic [ROW_W-1:0]    row_next;
    logic [WIDTH_W-1:0]  col_inc;
    logic [HEIGHT_W-1:0] row_inc;
    logic                row_end;
    logic                frame_end;

    assign col_inc   = WIDTH_W'(col_reg) + WIDTH_W'(1);
    assign row_inc   = HEIGHT_W'(row_reg) + HEIGHT_W'(1);
    assign row_end   = (col_inc >= cfg.width);
    assign frame_end = (row_inc >= cfg.height);

    // Describe the pixel about to be taken
    always_comb
    begin
        pos.col  = col_reg;
        pos.row  = row_reg;
        pos.emit = (row_reg >= ROW_W'(LINES)) && (col_reg >= COL_W'(LINES));
        pos.last = (col_inc == cfg.width) && (row_inc == cfg.height);
    end

    // Advance in raster order; restart on a register write
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg.restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = frame_end ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

FILE: hw/rtl/bmf_pipe.sv
// ----------------------------------------------------------------------------
// bmf_pipe
// Window datapath: column sums, window sum, reciprocal divide, output register.
// ----------------------------------------------------------------------------
module bmf_pipe (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  bmf_pkg::scan_pos_t                pos,
    input  logic [bmf_pkg::PIX_W-1:0]         pixel,
    input  logic [bmf_pkg::LINE_W-1:0]        line_rd,
    output logic                              pixel_stall,
    output logic                              line_wr_en,
    output logic [bmf_pkg::LADDR_W-1:0]       line_wr_addr,
    output logic [bmf_pkg::LINE_W-1:0]        line_wr_data,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic [bmf_pkg::PIX_W-1:0]         mean_value,
    output logic [bmf_pkg::ROW_W-1:0]         center_row,
    output logic [bmf_pkg::COL_W-1:0]         center_col,
    output logic                              frame_last
);

    import bmf_pkg::*;

    // Stage 1: pixel with its line buffer column
    logic              s1_valid_reg;
    scan_pos_t         s1_pos_reg;
    logic [PIX_W-1:0]  s1_pixel_reg;

    // Stage 2: column sums of the window
    logic [CSUM_W-1:0] colsum_reg [WIN];
    logic              s2_valid_reg;
    result_tag_t       s2_tag_reg;

    // Stage 3: window sum
    logic              s3_valid_reg;
    result_tag_t       s3_tag_reg;
    logic [SUM_W-1:0]  s3_sum_reg;

    // Output register
    logic              out_valid_reg;
    result_tag_t       out_tag_reg;
    logic [PIX_W-1:0]  out_mean_reg;

    logic              out_free;
    logic              s3_free;
    logic              s2_free;
    logic              s1_free;
    logic              s1_adv;
    logic              s2_adv;
    logic              s3_adv;
    logic [CSUM_W-1:0] colsum_new;
    logic [SUM_W-1:0]  win_sum;
    logic [PROD_W-1:0] prod;
    result_tag_t       s1_tag;

    // Handshake: a stage moves when the next one is empty or moving
    assign out_free = !out_valid_reg || !result_stall;
    assign s3_free  = !s3_valid_reg || out_free;
    assign s2_free  = !s2_valid_reg || s3_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign s1_adv   = s1_valid_reg && s2_free;
    assign s2_adv   = s2_valid_reg && s3_free;
    assign s3_adv   = s3_valid_reg && out_free;

    assign pixel_stall = !s1_free;

    // Sum the new column: incoming pixel plus the rows above it
    always_comb
    begin
        colsum_new = CSUM_W'(s1_pixel_reg);
        for (int k = 0; k < LINES; k++)
        begin
            colsum_new = colsum_new + CSUM_W'(line_rd[k*PIX_W +: PIX_W]);
        end
    end

    // Push the pixel down the column word; the oldest row drops out
    assign line_wr_en   = s1_adv;
    assign line_wr_addr = LADDR_W'(s1_pos_reg.col);
    assign line_wr_data = {line_rd[LINE_W-PIX_W-1:0], s1_pixel_reg};

    // Center of the window that this pixel completes
    always_comb
    begin
        s1_tag.center_row = s1_pos_reg.row - ROW_W'(RADIUS);
        s1_tag.center_col = s1_pos_reg.col - COL_W'(RADIUS);
        s1_tag.last       = s1_pos_reg.last;
    end

    // Add the column sums across the window
    always_comb
    begin
        win_sum = '0;
        for (int k = 0; k < WIN; k++)
        begin
            win_sum = win_sum + SUM_W'(colsum_reg[k]);
        end
    end

    // Floor divide by the window area
    assign prod = PROD_W'(s3_sum_reg) * PROD_W'(RECIP);

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                s2_valid_reg <= s1_pos_reg.emit;
            end
            else if (s2_adv)
            begin
                s2_valid_reg <= 1'b0;
            end

            if (s2_adv)
            begin
                s3_valid_reg <= 1'b1;
            end
            else if (s3_adv)
            begin
                s3_valid_reg <= 1'b0;
            end

            if (s3_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pos_reg   <= pos;
            s1_pixel_reg <= pixel;
        end

        if (s1_adv)
        begin
            colsum_reg[0] <= colsum_new;
            for (int k = 1; k < WIN; k++)
            begin
                colsum_reg[k] <= colsum_reg[k-1];
            end
            s2_tag_reg <= s1_tag;
        end

        if (s2_adv)
        begin
            s3_sum_reg <= win_sum;
            s3_tag_reg <= s2_tag_reg;
        end

        if (s3_adv)
        begin
            out_mean_reg <= prod[RECIP_SHIFT +: PIX_W];
            out_tag_reg  <= s3_tag_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign mean_value   = out_mean_reg;
    assign center_row   = out_tag_reg.center_row;
    assign center_col   = out_tag_reg.center_col;
    assign frame_last   = out_tag_reg.last;

endmodule

FILE: hw/rtl/bmf_checker.sv
// ----------------------------------------------------------------------------
// bmf_checker
// Port-level checks of the box mean filter, bound to the top level.
// ----------------------------------------------------------------------------
module bmf_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              psel,
    input logic                              penable,
    input logic                              pwrite,
    input logic [bmf_pkg::APB_ADDR_W-1:0]    paddr,
    input logic [bmf_pkg::APB_DATA_W-1:0]    pwdata,
    input logic [bmf_pkg::APB_DATA_W-1:0]    prdata,
    input logic                              pready,
    input logic [bmf_pkg::PIX_W-1:0]         pixel,
    input logic                              pixel_valid,
    input logic                              pixel_stall,
    input logic [bmf_pkg::PIX_W-1:0]         mean_value,
    input logic [bmf_pkg::ROW_W-1:0]         center_row,
    input logic [bmf_pkg::COL_W-1:0]         center_col,
    input logic                              frame_last,
    input logic                              result_valid,
    input logic                              result_stall
);

    import bmf_pkg::*;

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=>
            result_valid && $stable(mean_value) && $stable(center_row) &&
            $stable(center_col) && $stable(frame_last))
    else $error("stalled result changed");

    // Never stall requests while the output register is empty
    assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !pixel_stall)
    else $error("pixel request stalled with empty output");

    // Read back a written width
    assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready &&
         paddr[APB_ADDR_W-1:2] == REG_IMAGE_WIDTH) ##1
        (paddr[APB_ADDR_W-1:2] == REG_IMAGE_WIDTH) |->
            prdata[WIDTH_W-1:0] == $past(pwdata[WIDTH_W-1:0]))
    else $error("image width readback mismatch");

    // Read back a written height
    assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready &&
         paddr[APB_ADDR_W-1:2] == REG_IMAGE_HEIGHT) ##1
        (paddr[APB_ADDR_W-1:2] == REG_IMAGE_HEIGHT) |->
            prdata[HEIGHT_W-1:0] == $past(pwdata[HEIGHT_W-1:0]))
    else $error("image height readback mismatch");

endmodule

bind box_mean_filter bmf_checker u_bmf_checker (.*);

FILE: tb/sv/box_mean_filter_tb.sv
// ----------------------------------------------------------------------------
// box_mean_filter_tb
// Self-checking bench for the box mean filter.
// ----------------------------------------------------------------------------
// Drives frames of grey pixels through the block and predicts every window
// mean, its center position and the end-of-frame mark. A scoreboard notes
// each accepted pixel request and checks each accepted result in order.
// Frame sizes are set over the register port only while the pipeline is
// empty. The run covers a directed part (a single full window, zero sizes),
// a pressure frame in which the result side holds off long enough to back
// up the pixel input, random frames of random sizes (some cut short by a
// restart), and a short partial frame under each oversize frame size. Both
// sides idle at random in the first two of three phases; neither does in the third.
// ----------------------------------------------------------------------------
module box_mean_filter_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import bmf_pkg::*;

    localparam int STALL_LIMIT   = 3000;
    localparam int HOLD_CYCLES   = 400;
    localparam int MAX_REPORTS   = 10;
    localparam int RANDOM_ITEMS  = 600;
    localparam int SETTLE_CYCLES = 8;
    localparam int RESET_CYCLES  = 8;
    localparam int CLAMP_PIXELS  = 20;

    typedef enum {FILL_RANDOM, FILL_BLACK, FILL_WHITE} fill_t;

    typedef struct {
        logic [PIX_W-1:0] mean;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             is_last;
    } window_mean_t;

    // Window mean predictor and ordered store of expected results
    class box_mean_scoreboard;
        logic [WIDTH_W-1:0]  width_reg;
        logic [HEIGHT_W-1:0] height_reg;
        logic [PIX_W-1:0]    lines [WIN][MAX_WIDTH];
        int unsigned         row_pos;
        int unsigned         col_pos;
        window_mean_t        means_q[$];
        int                  failures;

        function new();
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            row_pos    = 0;
            col_pos    = 0;
            failures   = 0;
        endfunction

        function void report_failure(string what);
            failures++;
            if (failures <= MAX_REPORTS)
                $display("ERROR: %s", what);
        endfunction

        // Any frame size write restarts the frame at the top left pixel
        function void write_reg(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] value);
            if (idx == REG_IMAGE_WIDTH)
                width_reg = value[WIDTH_W-1:0];
            else if (idx == REG_IMAGE_HEIGHT)
                height_reg = value[HEIGHT_W-1:0];
            else
                return;
            row_pos = 0;
            col_pos = 0;
        endfunction

        function logic [APB_DATA_W-1:0] reg_value(logic [REG_IDX_W-1:0] idx);
            if (idx == REG_IMAGE_WIDTH)
                return APB_DATA_W'(width_reg);
            return APB_DATA_W'(height_reg);
        endfunction

        // Zero counts as one, oversize saturates
        function int unsigned frame_width();
            if (width_reg == 0)
                return 1;
            if (width_reg > MAX_WIDTH)
                return MAX_WIDTH;
            return width_reg;
        endfunction

        function int unsigned frame_height();
            if (height_reg == 0)
                return 1;
            if (height_reg > MAX_HEIGHT)
                return MAX_HEIGHT;
            return height_reg;
        endfunction

        // Store the pixel and, once a full inner window is complete, queue its mean
        function void note_pixel(logic [PIX_W-1:0] pix);
            int unsigned  w;
            int unsigned  h;
            int unsigned  r;
            int unsigned  c;
            int unsigned  total;
            window_mean_t m;
            w = frame_width();
            h = frame_height();
            if (col_pos >= w)
                col_pos = 0;
            if (row_pos >= h)
                row_pos = 0;
            r = row_pos;
            c = col_pos;
            lines[r % WIN][c] = pix;
            if (r >= 2 * RADIUS && c >= 2 * RADIUS)
            begin
                total = 0;
                for (int i = 0; i < WIN; i++)
                    for (int j = 0; j < WIN; j++)
                        total += lines[(r - i) % WIN][c - j];
                m.mean    = PIX_W'(total / AREA);
                m.row     = ROW_W'(r - RADIUS);
                m.col     = COL_W'(c - RADIUS);
                m.is_last = (r == h - 1) && (c == w - 1);
                means_q.push_back(m);
            end
            // Advance the raster position
            col_pos = c + 1;
            if (col_pos >= w)
            begin
                col_pos = 0;
                row_pos = r + 1;
                if (row_pos >= h)
                    row_pos = 0;
            end
        endfunction

        function void check_result(logic [PIX_W-1:0] mean, logic [ROW_W-1:0] row,
                                   logic [COL_W-1:0] col, logic is_last);
            window_mean_t m;
            if (means_q.size() == 0)
            begin
                report_failure($sformatf("unexpected result: mean %0d row %0d col %0d last %0b",
                                         mean, row, col, is_last));
                return;
            end
            m = means_q.pop_front();
            if (mean !== m.mean || row !== m.row || col !== m.col || is_last !== m.is_last)
                report_failure($sformatf({"result mismatch: expected mean %0d row %0d col %0d ",
                                          "last %0b, got mean %0d row %0d col %0d last %0b"},
                                         m.mean, m.row, m.col, m.is_last,
                                         mean, row, col, is_last));
        endfunction

        function int pending();
            return means_q.size();
        endfunction
    endclass

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [APB_ADDR_W-1:0] paddr        = '0;
    logic [APB_DATA_W-1:0] pwdata       = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic [PIX_W-1:0]      pixel        = '0;
    logic                  pixel_valid  = 1'b0;
    logic                  pixel_stall;
    logic [PIX_W-1:0]      mean_value;
    logic [ROW_W-1:0]      center_row;
    logic [COL_W-1:0]      center_col;
    logic                  frame_last;
    logic                  result_valid;
    logic                  result_stall = 1'b0;

    box_mean_scoreboard filter_sb;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int pixels_sent   = 0;
    int quiet_cycles  = 0;
    int hold_left     = 0;
    bit hold_start    = 1'b0;
    bit hold_done     = 1'b0;

    always #5ns clk = ~clk;

    box_mean_filter DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .pixel        (pixel),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .mean_value   (mean_value),
        .center_row   (center_row),
        .center_col   (center_col),
        .frame_last   (frame_last),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

    // Check accepted results; stall at random, or hold off for a long stretch once
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            filter_sb.check_result(mean_value, center_row, center_col, frame_last);
        if (hold_start && !hold_done)
        begin
            hold_left    <= HOLD_CYCLES;
            hold_done    <= 1'b1;
            result_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left    <= hold_left - 1;
            result_stall <= 1'b1;
        end
        else
            result_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall) || (psel && penable))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Pick the idling phase from the number of pixels sent so far
    task automatic set_idling();
        if (pixels_sent < RANDOM_ITEMS / 3)
        begin
            send_idle_pct = 19;
            recv_idle_pct = 77;
        end
        else if (pixels_sent < 2 * RANDOM_ITEMS / 3)
        begin
            send_idle_pct = 77;
            recv_idle_pct = 19;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endtask

    // Offer one pixel request and hold it until taken
    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pixel_valid <= 1'b0;
            @(posedge clk);
        end
        pixel       <= pix;
        pixel_valid <= 1'b1;
        @(posedge clk);
        while (pixel_stall)
            @(posedge clk);
        filter_sb.note_pixel(pix);
    endtask

    task automatic send_pixels(input int unsigned count, input fill_t fill);
        logic [PIX_W-1:0] pix;
        for (int unsigned i = 0; i < count; i++)
        begin
            case (fill)
                FILL_BLACK: pix = '0;
                FILL_WHITE: pix = '1;
                default:    pix = PIX_W'($urandom_range(255));
            endcase
            send_pixel(pix);
            pixels_sent++;
        end
    endtask

    // Drop valid, wait for every expected result, then let the pipeline empty
    task automatic drain_pipeline();
        pixel_valid <= 1'b0;
        while (filter_sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // One register access: setup cycle, then access cycle until ready
    task automatic apb_access(input logic write_en, input logic [REG_IDX_W-1:0] idx,
                              input logic [APB_DATA_W-1:0] value,
                              output logic [APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write_en;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] value);
        logic [APB_DATA_W-1:0] unused;
        apb_access(1'b1, idx, value, unused);
        filter_sb.write_reg(idx, value);
    endtask

    task automatic check_reg(input logic [REG_IDX_W-1:0] idx);
        logic [APB_DATA_W-1:0] rdata;
        logic [APB_DATA_W-1:0] expected;
        apb_access(1'b0, idx, '0, rdata);
        expected = filter_sb.reg_value(idx);
        if (rdata !== expected)
            filter_sb.report_failure($sformatf("register %0d read: expected %0d, got %0d",
                                               idx, expected, rdata));
    endtask

    initial
    begin
        int unsigned w;
        int unsigned h;
        int unsigned frame_pixels;
        int unsigned frames;
        fill_t       fill;
        filter_sb = new();
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_idling();

        // Reset values of the frame size
        check_reg(REG_IMAGE_WIDTH);
        check_reg(REG_IMAGE_HEIGHT);

        // Single full window of white: top mean, and it closes the frame
        write_reg(REG_IMAGE_WIDTH, 5);
        check_reg(REG_IMAGE_WIDTH);
        write_reg(REG_IMAGE_HEIGHT, 5);
        check_reg(REG_IMAGE_HEIGHT);
        send_pixels(25, FILL_WHITE);
        drain_pipeline();

        // Zero sizes act as a one pixel frame: no results
        write_reg(REG_IMAGE_WIDTH, 0);
        write_reg(REG_IMAGE_HEIGHT, 0);
        check_reg(REG_IMAGE_WIDTH);
        check_reg(REG_IMAGE_HEIGHT);
        send_pixels(3, FILL_RANDOM);
        drain_pipeline();

        // Dense frame while the result side holds off: the input must back up
        write_reg(REG_IMAGE_WIDTH, 16);
        write_reg(REG_IMAGE_HEIGHT, 8);
        hold_start = 1'b1;
        send_pixels(128, FILL_RANDOM);
        drain_pipeline();

        // Random frames, mostly whole, some cut short by the next restart
        while (pixels_sent < RANDOM_ITEMS)
        begin
            set_idling();
            case ($urandom_range(99)) inside
                [0:69]:  w = $urandom_range(5, 14);
                [70:79]: w = $urandom_range(1, 4);
                [80:84]: w = 0;
                default: w = $urandom_range(15, 40);
            endcase
            case ($urandom_range(99)) inside
                [0:74]:  h = $urandom_range(5, 10);
                [75:84]: h = $urandom_range(1, 4);
                [85:89]: h = 0;
                default: h = $urandom_range(11, 16);
            endcase
            case ($urandom_range(3))
                0: write_reg(REG_IMAGE_WIDTH, w);
                1: write_reg(REG_IMAGE_HEIGHT, h);
                2:
                begin
                    write_reg(REG_IMAGE_HEIGHT, h);
                    write_reg(REG_IMAGE_WIDTH, w);
                end
                default:
                begin
                    write_reg(REG_IMAGE_WIDTH, w);
                    write_reg(REG_IMAGE_HEIGHT, h);
                end
            endcase
            frame_pixels = filter_sb.frame_width() * filter_sb.frame_height();
            frames = (frame_pixels > 300) ? 1 : $urandom_range(1, 2);
            case ($urandom_range(9))
                0:       fill = FILL_BLACK;
                1:       fill = FILL_WHITE;
                default: fill = FILL_RANDOM;
            endcase
            repeat (frames)
                send_pixels(frame_pixels, fill);
            if ($urandom_range(4) == 0)
                send_pixels($urandom_range(1, frame_pixels), fill);
            drain_pipeline();
        end

        // Oversize width saturates to the line store length; send the first pixels only
        set_idling();
        write_reg(REG_IMAGE_WIDTH, 2047);
        write_reg(REG_IMAGE_HEIGHT, 5);
        check_reg(REG_IMAGE_WIDTH);
        send_pixels(CLAMP_PIXELS, FILL_RANDOM);
        drain_pipeline();

        // Oversize height saturates; send the first pixels only
        write_reg(REG_IMAGE_WIDTH, 5);
        write_reg(REG_IMAGE_HEIGHT, 8191);
        check_reg(REG_IMAGE_HEIGHT);
        send_pixels(CLAMP_PIXELS, FILL_RANDOM);
        drain_pipeline();

        repeat (20)
            @(posedge clk);
        if (filter_sb.failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
